>>> hw/rtl/cws_pkg.sv
package cws_pkg;

  localparam int unsigned NumCells  = 8;
  localparam int unsigned HalfCells = NumCells / 2;
  localparam int unsigned ChipW     = 8;
  localparam int unsigned HistW     = 7;
  localparam int unsigned Pn9W      = 9;

  localparam logic [Pn9W-1:0] PnSeed = 9'h1FF;

  // spread_mode codes; the spare code behaves as ModeQuad
  localparam logic [1:0] ModeWhiten = 2'd0;
  localparam logic [1:0] ModeDouble = 2'd1;
  localparam logic [1:0] ModeQuad   = 2'd2;

  localparam logic [3:0] ChipsOne  = 4'h3;
  localparam logic [3:0] ChipsZero = 4'hC;

  typedef struct packed {
    logic             vld;
    logic             last;
    logic [ChipW-1:0] chip;
  } cws_cell_t;

  // encoded item handed from the stage register to the cell row
  typedef struct packed {
    logic                           vld;
    logic                           wide;
    logic [NumCells-1:0][ChipW-1:0] chips;
  } cws_load_t;

  function automatic logic [Pn9W-1:0] pn9_adv8(input logic [Pn9W-1:0] pn);
    logic [Pn9W-1:0] s;
    s = pn;
    for (int i = 0; i < 8; i++) begin
      s = {s[0] ^ s[5], s[Pn9W-1:1]};
    end
    return s;
  endfunction

  function automatic logic [ChipW-1:0] dbl_nib(input logic [3:0] nib);
    logic [ChipW-1:0] res;
    res = '0;
    for (int i = 0; i < 4; i++) begin
      res[2*i +: 2] = {2{nib[i]}};
    end
    return res;
  endfunction

  function automatic logic [3:0] spread4(input logic b);
    return b ? ChipsOne : ChipsZero;
  endfunction

endpackage

>>> hw/rtl/cws_in_if.sv
interface cws_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_packet;

  modport source (output valid, output data_byte, output first_of_packet, input ready);
  modport sink   (input valid, input data_byte, input first_of_packet, output ready);
endinterface

>>> hw/rtl/cws_out_if.sv
interface cws_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] chip_byte;
  logic       last_of_run;

  modport source (output valid, output chip_byte, output last_of_run, input ready);
  modport sink   (input valid, input chip_byte, input last_of_run, output ready);
endinterface

>>> hw/rtl/conv_whiten_spread_encoder_top.sv
// The first chip byte of an item passes through the stage register and is then loaded
//   into the cell row once the row can take it; the head cell drives it onto the output.
// Throughput: one chip byte per cycle on the output while out_o.ready is high; an item
//   makes 4 chip bytes in modes 0 and 1 and 8 in mode 2 (and the spare code 3).
// A one-item stage register lets the next byte transfer while chips still drain.
// Reset: history cleared, PN9 set to all ones, spread_mode 0, no chips pending.
module conv_whiten_spread_encoder_top
  import cws_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_data_i,
  cws_in_if.sink     in_i,
  cws_out_if.source  out_o
);

  logic [1:0] mode_q;
  logic       take;
  cws_load_t  load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeWhiten;
    end else if (cfg_we_i) begin
      mode_q <= cfg_data_i;
    end
  end

  cws_encoder u_encoder (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mode_i (mode_q),
    .take_i (take),
    .in_i   (in_i),
    .load_o (load)
  );

  cws_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .take_o (take),
    .out_o  (out_o)
  );

endmodule

>>> hw/rtl/cws_encoder.sv
module cws_encoder
  import cws_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] mode_i,
  input  logic       take_i,
  cws_in_if.sink     in_i,
  output cws_load_t  load_o
);

  logic [HistW-1:0]               hist_q;
  logic [Pn9W-1:0]                pn_q;
  logic                           stage_vld_q, stage_vld_d;
  logic                           stage_wide_q;
  logic [NumCells-1:0][ChipW-1:0] stage_chips_q;

  logic [HistW-1:0]               hist;
  logic [Pn9W-1:0]                pn0, pn8, pn16, pn_d;
  logic [HistW+ChipW-1:0]         win;
  logic [HistW-1:0]               r;
  logic [NumCells-1:0]            a0, a1;
  logic [ChipW-1:0]               coded0, coded1, c0, c1;
  logic                           whiten, narrow, acc;
  logic [NumCells-1:0][ChipW-1:0] chips;

  assign acc      = in_i.valid && in_i.ready;
  assign in_i.ready = !stage_vld_q || take_i;

  always_comb begin
    hist   = in_i.first_of_packet ? '0 : hist_q;
    pn0    = in_i.first_of_packet ? PnSeed : pn_q;
    win    = {hist, in_i.data_byte};
    r      = '0;
    a0     = '0;
    a1     = '0;
    coded0 = '0;
    coded1 = '0;
    // each pair looks at a 7-bit window ending at its own bit
    for (int j = 0; j < NumCells; j++) begin
      r     = win[(7 - j) +: HistW];
      a0[j] = r[0] ^ r[3] ^ r[4] ^ r[5] ^ r[6];
      a1[j] = r[0] ^ r[1] ^ r[3] ^ r[4] ^ r[6];
    end
    for (int j = 0; j < 4; j++) begin
      coded0[7 - 2*j] = a0[j];
      coded0[6 - 2*j] = a1[j];
      coded1[7 - 2*j] = a0[j + 4];
      coded1[6 - 2*j] = a1[j + 4];
    end
    pn8    = pn9_adv8(pn0);
    pn16   = pn9_adv8(pn8);
    whiten = (mode_i == ModeWhiten);
    narrow = (mode_i == ModeWhiten) || (mode_i == ModeDouble);
    c0     = whiten ? (coded0 ^ pn0[ChipW-1:0]) : coded0;
    c1     = whiten ? (coded1 ^ pn8[ChipW-1:0]) : coded1;
    pn_d   = whiten ? pn16 : pn0;
    chips  = '0;
    if (narrow) begin
      chips[0] = dbl_nib(c0[7:4]);
      chips[1] = dbl_nib(c0[3:0]);
      chips[2] = dbl_nib(c1[7:4]);
      chips[3] = dbl_nib(c1[3:0]);
    end else begin
      for (int j = 0; j < NumCells; j++) begin
        chips[j] = {spread4(a0[j]), spread4(a1[j])};
      end
    end
  end

  always_comb begin
    stage_vld_d = stage_vld_q;
    if (acc) begin
      stage_vld_d = 1'b1;
    end else if (take_i) begin
      stage_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q      <= '0;
      pn_q        <= PnSeed;
      stage_vld_q <= 1'b0;
    end else begin
      stage_vld_q <= stage_vld_d;
      if (acc) begin
        // history after a byte is simply its seven newest bits
        hist_q <= in_i.data_byte[HistW-1:0];
        pn_q   <= pn_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      stage_wide_q  <= !narrow;
      stage_chips_q <= chips;
    end
  end

  assign load_o.vld   = stage_vld_q;
  assign load_o.wide  = stage_wide_q;
  assign load_o.chips = stage_chips_q;

`ifndef SYNTHESIS
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_vld_q && !take_i |=> stage_vld_q)
    else $error("stage item dropped before hand-off");
  a_take_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i |-> stage_vld_q)
    else $error("hand-off without a staged item");
  a_acc_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> stage_vld_q)
    else $error("transfer did not fill the stage");
`endif

endmodule

>>> hw/rtl/cws_chip_cell.sv
module cws_chip_cell
  import cws_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  logic      shift_i,
  input  cws_cell_t load_val_i,
  input  cws_cell_t next_i,
  output cws_cell_t cell_o
);

  logic             vld_q, vld_d;
  logic             last_q, last_d;
  logic [ChipW-1:0] chip_q, chip_d;

  always_comb begin
    priority if (load_i) begin
      vld_d  = load_val_i.vld;
      last_d = load_val_i.last;
      chip_d = load_val_i.chip;
    end else if (shift_i) begin
      // advance towards the head
      vld_d  = next_i.vld;
      last_d = next_i.last;
      chip_d = next_i.chip;
    end else begin
      vld_d  = vld_q;
      last_d = last_q;
      chip_d = chip_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    chip_q <= chip_d;
  end

  assign cell_o.vld  = vld_q;
  assign cell_o.last = last_q;
  assign cell_o.chip = chip_q;

endmodule

>>> hw/rtl/cws_chain.sv
module cws_chain
  import cws_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cws_load_t load_i,
  output logic      take_o,
  cws_out_if.source out_o
);

  cws_cell_t [NumCells-1:0] row;
  logic      [NumCells-1:0] vld;
  logic                     shift;

  assign shift  = row[0].vld && out_o.ready;
  // reload when the row is empty, or once the head holds the final byte and it leaves
  assign take_o = load_i.vld && (!row[0].vld || (!row[1].vld && out_o.ready));

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    cws_cell_t load_val;
    cws_cell_t next;

    assign load_val.vld  = (i < HalfCells) || load_i.wide;
    assign load_val.last = load_i.wide ? (i == NumCells - 1) : (i == HalfCells - 1);
    assign load_val.chip = load_i.chips[i];

    if (i == NumCells - 1) begin : g_tail
      assign next = '0;
    end else begin : g_body
      assign next = row[i+1];
    end

    assign vld[i] = row[i].vld;

    cws_chip_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .load_i     (take_o),
      .shift_i    (shift),
      .load_val_i (load_val),
      .next_i     (next),
      .cell_o     (row[i])
    );
  end

  assign out_o.valid       = row[0].vld;
  assign out_o.chip_byte   = row[0].chip;
  assign out_o.last_of_run = row[0].last;

`ifndef SYNTHESIS
  a_packed_from_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld & (vld + {{(NumCells-1){1'b0}}, 1'b1})) == '0)
    else $error("gap in the cell row");
  a_last_is_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row[0].vld && row[0].last |-> !row[1].vld)
    else $error("bytes queued behind the final byte of a run");
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |=> row[0].vld && !row[0].last && row[HalfCells-1].vld)
    else $error("loaded run not at the head");
`endif

endmodule

>>> tb/testbench.sv
module testbench;
  import cws_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ModeSpare = 2'd3;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } payload_t;

  typedef struct packed {
    logic [ChipW-1:0] chip;
    logic             last;
  } chip_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [1:0] cfg_data;

  cws_in_if  in_bus ();
  cws_out_if out_bus ();

  conv_whiten_spread_encoder_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  // predictor state
  logic [HistW-1:0] enc_hist;
  logic [Pn9W-1:0]  pn_state;
  logic [1:0]       spread_sel;

  payload_t    bytes_pending[$];
  chip_t       chips_due[$];
  int unsigned fail_count;
  int unsigned cycle_count;

  // driver and receiver pacing
  bit          byte_taken;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned ready_tick;
  int unsigned ready_style;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Encode one byte and queue the chip bytes it must produce.
  function automatic void encode_byte(input logic [7:0] data, input logic first);
    logic [HistW-1:0] r;
    logic [1:0]       pair[8];
    logic [7:0]       coded[2];
    logic [7:0]       c;
    chip_t            hi;
    chip_t            lo;
    chip_t            q;
    if (first) begin
      enc_hist = '0;
      pn_state = PnSeed;
    end
    for (int j = 0; j < 8; j++) begin
      r = {enc_hist[HistW-2:0], data[7-j]};
      pair[j][1] = r[0] ^ r[3] ^ r[4] ^ r[5] ^ r[6];
      pair[j][0] = r[0] ^ r[1] ^ r[3] ^ r[4] ^ r[6];
      enc_hist = r;
    end
    coded[0] = {pair[0], pair[1], pair[2], pair[3]};
    coded[1] = {pair[4], pair[5], pair[6], pair[7]};
    if (spread_sel == ModeWhiten || spread_sel == ModeDouble) begin
      for (int h = 0; h < 2; h++) begin
        c = coded[h];
        if (spread_sel == ModeWhiten) begin
          c = c ^ pn_state[7:0];
          for (int s = 0; s < 8; s++) begin
            pn_state = {pn_state[0] ^ pn_state[5], pn_state[Pn9W-1:1]};
          end
        end
        // each coded bit becomes two equal chips, earliest in the MSB
        for (int k = 0; k < 8; k++) begin
          hi.chip[k] = c[4 + k / 2];
          lo.chip[k] = c[k / 2];
        end
        hi.last = 1'b0;
        lo.last = (h == 1);
        chips_due.push_back(hi);
        chips_due.push_back(lo);
      end
    end else begin
      for (int j = 0; j < 8; j++) begin
        q.chip = {pair[j][1] ? ChipsOne : ChipsZero, pair[j][0] ? ChipsOne : ChipsZero};
        q.last = (j == 7);
        chips_due.push_back(q);
      end
    end
  endfunction

  // Sample transfers on both channels, predict and check.
  always @(posedge clk_i) begin
    chip_t want;
    cycle_count++;
    if (cfg_we) begin
      spread_sel = cfg_data;
    end
    if (rst_ni && in_bus.valid && in_bus.ready) begin
      encode_byte(in_bus.data_byte, in_bus.first_of_packet);
      void'(bytes_pending.pop_front());
      byte_taken = 1'b1;
    end
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (chips_due.size() == 0) begin
        fail_count++;
        if (fail_count <= ReportLimit) begin
          $display("unexpected chip byte %02h last %0b",
                   out_bus.chip_byte, out_bus.last_of_run);
        end
      end else begin
        want = chips_due.pop_front();
        if (out_bus.chip_byte !== want.chip || out_bus.last_of_run !== want.last) begin
          fail_count++;
          if (fail_count <= ReportLimit) begin
            $display("chip byte: expected %02h last %0b, got %02h last %0b",
                     want.chip, want.last, out_bus.chip_byte, out_bus.last_of_run);
          end
        end
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("conv_whiten_spread_encoder_top: mismatch");
      $finish;
    end
  end

  // Sender: bursts of random length with random gaps between them.
  always @(negedge clk_i) begin
    if (!(in_bus.valid && !byte_taken)) begin
      byte_taken = 1'b0;
      if (gap_left > 0) begin
        in_bus.valid <= 1'b0;
        gap_left--;
      end else if (rst_ni && bytes_pending.size() > 0) begin
        in_bus.valid           <= 1'b1;
        in_bus.data_byte       <= bytes_pending[0].data;
        in_bus.first_of_packet <= bytes_pending[0].first;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
        end else begin
          burst_left--;
        end
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: switch between stall styles every so often.
  always @(negedge clk_i) begin
    ready_tick++;
    if (ready_tick % 97 == 0) begin
      ready_style = $urandom_range(0, 3);
    end
    case (ready_style)
      0: out_bus.ready <= 1'b1;
      1: out_bus.ready <= 1'($urandom_range(0, 1));
      2: out_bus.ready <= ($urandom_range(0, 4) == 0);
      default: out_bus.ready <= (ready_tick % 5 != 0);
    endcase
  end

  task automatic wait_drained();
    while (bytes_pending.size() != 0 || chips_due.size() != 0 || in_bus.valid) begin
      @(posedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [1:0] mode, input bit directed, input int unsigned count);
    payload_t    item;
    int unsigned pkt_left;
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= mode;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    if (directed) begin
      bytes_pending.push_back('{data: 8'h00, first: 1'b1});
      bytes_pending.push_back('{data: 8'hFF, first: 1'b0});
      bytes_pending.push_back('{data: 8'h80, first: 1'b0});
      bytes_pending.push_back('{data: 8'h01, first: 1'b1});
      bytes_pending.push_back('{data: 8'hAA, first: 1'b0});
      bytes_pending.push_back('{data: 8'h55, first: 1'b1});
    end
    pkt_left = 0;
    for (int n = 0; n < count; n++) begin
      item.data = 8'($urandom_range(0, 255));
      if (pkt_left == 0) begin
        // open a new packet
        pkt_left   = $urandom_range(1, 16);
        item.first = 1'b1;
      end else begin
        // now and then break the packet with a stray start
        item.first = ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1)) : 1'b0;
      end
      pkt_left--;
      bytes_pending.push_back(item);
    end
  endtask

  initial begin
    rst_ni                 = 1'b0;
    cfg_we                 = 1'b0;
    cfg_data               = '0;
    in_bus.valid           = 1'b0;
    in_bus.data_byte       = '0;
    in_bus.first_of_packet = 1'b0;
    out_bus.ready          = 1'b0;
    enc_hist               = '0;
    pn_state               = PnSeed;
    spread_sel             = ModeWhiten;
    fail_count             = 0;
    cycle_count            = 0;
    byte_taken             = 1'b0;
    burst_left             = 1;
    gap_left               = 0;
    ready_tick             = 0;
    ready_style            = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_phase(ModeWhiten, 1'b1, 42);
    run_phase(ModeDouble, 1'b1, 40);
    run_phase(ModeQuad, 1'b1, 40);
    run_phase(ModeSpare, 1'b1, 40);
    run_phase(ModeWhiten, 1'b0, 45);
    run_phase(ModeQuad, 1'b0, 40);
    run_phase(ModeDouble, 1'b0, 40);
    wait_drained();
    repeat (16) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("conv_whiten_spread_encoder_top: match");
    end else begin
      $display("conv_whiten_spread_encoder_top: mismatch");
    end
    $finish;
  end

endmodule
